/* rtl/core/bsts_pkg.sv */
// Package: shared constants, codes and controller/datapath signal bundles.
`timescale 1ns / 1ps
package bsts_pkg;

    // Default sizes
    localparam int BATCH_MAX_DEF  = 64;
    localparam int LENGTH_MAX_DEF = 4096;

    // Generator constants
    localparam logic [63:0] GOLDEN   = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] STAR_MUL = 64'd2685821657736338717;
    localparam int XS_SHIFT_A = 12;
    localparam int XS_SHIFT_B = 25;
    localparam int XS_SHIFT_C = 27;
    localparam int DRAW_BITS  = 64;

    // Operation codes
    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_SHUFFLE = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_BAD_LEN    = 2'd2;
    localparam logic [1:0] ST_NOT_FILLED = 2'd3;

    // Configuration register indexes
    localparam int CFG_IW = 1;
    localparam logic [CFG_IW-1:0] REG_CAPACITY   = 1'd0;
    localparam logic [CFG_IW-1:0] REG_MAX_LENGTH = 1'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic init_step;
        logic accept;
        logic finish;
        logic xs;
        logic mul0;
        logic mul1;
        logic mul2;
        logic div_step;
        logic swap_rd;
        logic wr_i;
        logic wr_j;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic       init_last;
        logic       shuf_run;
        logic       div_last;
        logic       idx_one;
        logic       out_free;
        logic [1:0] in_kind;
    } stat_t;

endpackage

/* rtl/core/bsts_if.sv */
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps
interface bsts_req_if #(parameter int AW = 6, parameter int LW = 13);
    logic          valid;
    logic          ready;
    logic [1:0]    kind;
    logic [LW-1:0] seq_length;
    logic [63:0]   seed;
    logic [AW-1:0] position;

    modport source (output valid, kind, seq_length, seed, position, input ready);
    modport sink   (input valid, kind, seq_length, seed, position, output ready);
endinterface

interface bsts_rsp_if #(parameter int AW = 6, parameter int CW = 7, parameter int LW = 13);
    logic          valid;
    logic          ready;
    logic [1:0]    status;
    logic [AW-1:0] buffer_slot;
    logic [LW-1:0] length;
    logic [CW-1:0] filled;
    logic          is_full;
    logic          has_data;

    modport source (output valid, status, buffer_slot, length, filled, is_full, has_data,
                    input ready);
    modport sink   (input valid, status, buffer_slot, length, filled, is_full, has_data,
                    output ready);
endinterface

/* rtl/core/batch_slot_table_shuffler.sv */
// Add, read and clear register their result word once the output is free.
// Shuffle: with two or more positions filled it walks i from filled-1 down to 1;
//   each swap is xorshift, a shared 32x32 multiply, a bit-serial remainder of the
//   64-bit draw and table access on the memory ports. One item at a time.
// Reset: asynchronous, active low; then an init pass over every entry writes the identity
//   buffer numbers into the table while ready stays low. Config writes are taken always.
`timescale 1ns / 1ps
module batch_slot_table_shuffler
    import bsts_pkg::*;
#(
    parameter int BATCH_MAX  = BATCH_MAX_DEF,
    parameter int LENGTH_MAX = LENGTH_MAX_DEF,
    localparam int CW = $clog2(BATCH_MAX + 1),
    localparam int LW = $clog2(LENGTH_MAX + 1),
    localparam int DW = (LW > CW) ? LW : CW
)
(
    input  logic              clk,
    input  logic              rst_n,
    bsts_req_if.sink          req,
    bsts_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [DW-1:0]     cfg_data
);

    cmd_t  cmd;
    stat_t st;

    // Sequencer
    bsts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // Table, generator and result path
    bsts_dpath #(
        .BATCH_MAX  (BATCH_MAX),
        .LENGTH_MAX (LENGTH_MAX)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

/* rtl/core/bsts_ctrl.sv */
// Controller: sequencer for init pass, single ops and the shuffle walk.
`timescale 1ns / 1ps
module bsts_ctrl
    import bsts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_INIT = 11'b00000000001,
        S_IDLE = 11'b00000000010,
        S_DONE = 11'b00000000100,
        S_XS   = 11'b00000001000,
        S_M0   = 11'b00000010000,
        S_M1   = 11'b00000100000,
        S_M2   = 11'b00001000000,
        S_DIV  = 11'b00010000000,
        S_RD   = 11'b00100000000,
        S_WI   = 11'b01000000000,
        S_WJ   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (st.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (st.in_kind == KIND_SHUFFLE && st.shuf_run)
                    begin
                        state_next = S_XS;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_XS:
            begin
                cmd.xs     = 1'b1;
                state_next = S_M0;
            end
            S_M0:
            begin
                cmd.mul0   = 1'b1;
                state_next = S_M1;
            end
            S_M1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_M2;
            end
            S_M2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.swap_rd = 1'b1;
                state_next  = S_WI;
            end
            S_WI:
            begin
                cmd.wr_i   = 1'b1;
                state_next = S_WJ;
            end
            S_WJ:
            begin
                cmd.wr_j   = 1'b1;
                state_next = st.idx_one ? S_DONE : S_XS;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // Checks
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_div_to_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && st.div_last) |=> state_reg == S_RD)
        else $error("divider exit lost");
    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WI |-> $past(state_reg) == S_RD)
        else $error("swap write without read");

endmodule

/* rtl/core/bsts_dpath.sv */
// Datapath: position table memory, generator, multiplier, remainder unit, results.
`timescale 1ns / 1ps
module bsts_dpath
    import bsts_pkg::*;
#(
    parameter int BATCH_MAX  = BATCH_MAX_DEF,
    parameter int LENGTH_MAX = LENGTH_MAX_DEF,
    localparam int AW = $clog2(BATCH_MAX),
    localparam int CW = $clog2(BATCH_MAX + 1),
    localparam int LW = $clog2(LENGTH_MAX + 1),
    localparam int DW = (LW > CW) ? LW : CW
)
(
    input  logic              clk,
    input  logic              rst_n,
    bsts_req_if.sink          req,
    bsts_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [DW-1:0]     cfg_data,
    input  cmd_t              cmd,
    output stat_t             st
);

    localparam int EW = AW + LW;

    // Configuration registers
    logic [CW-1:0] cap_reg;
    logic [LW-1:0] max_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= CW'(BATCH_MAX);
            max_len_reg <= LW'(LENGTH_MAX);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_CAPACITY)
            begin
                cap_reg <= cfg_data[CW-1:0];
            end
            else if (cfg_index == REG_MAX_LENGTH)
            begin
                max_len_reg <= cfg_data[LW-1:0];
            end
        end
    end

    // Latched request word
    logic [1:0]    kind_reg;
    logic [LW-1:0] len_reg;
    logic [AW-1:0] pos_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= req.kind;
            len_reg  <= req.seq_length;
            pos_reg  <= req.position;
        end
    end

    // Control counters
    logic [CW-1:0] filled_reg, filled_next;
    logic [AW-1:0] init_cnt_reg;
    logic [AW-1:0] idx_reg;
    logic [5:0]    div_cnt_reg;
    logic [CW-1:0] rem_reg;

    // Table memory: {buffer number, length}
    logic [EW-1:0] mem [BATCH_MAX];
    logic [EW-1:0] rd_a_reg, rd_b_reg;
    logic          we, re_a;
    logic [AW-1:0] wa, ra;
    logic [EW-1:0] wd;
    logic [AW-1:0] j_idx;

    // Result decode
    logic [CW-1:0] eff_cap;
    logic          bad_len, is_full_now, add_ok, read_ok;

    assign j_idx       = rem_reg[AW-1:0];
    assign eff_cap     = (cap_reg > CW'(BATCH_MAX)) ? CW'(BATCH_MAX) : cap_reg;
    assign bad_len     = (len_reg == '0) || (len_reg > max_len_reg) ||
                         (len_reg > LW'(LENGTH_MAX));
    assign is_full_now = filled_reg >= eff_cap;
    assign add_ok      = (kind_reg == KIND_ADD) && !bad_len && !is_full_now;
    assign read_ok     = CW'(pos_reg) < filled_reg;

    // Write port select
    always_comb
    begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        priority if (cmd.init_step)
        begin
            we = 1'b1;
            wa = init_cnt_reg;
            wd = {init_cnt_reg, {LW{1'b0}}};
        end
        else if (cmd.finish && add_ok)
        begin
            we = 1'b1;
            wa = filled_reg[AW-1:0];
            wd = {rd_a_reg[EW-1:LW], len_reg};
        end
        else if (cmd.wr_i)
        begin
            we = 1'b1;
            wa = idx_reg;
            wd = rd_b_reg;
        end
        else if (cmd.wr_j)
        begin
            we = 1'b1;
            wa = j_idx;
            wd = rd_a_reg;
        end
    end

    // Read port A address
    always_comb
    begin
        re_a = cmd.accept || cmd.swap_rd;
        if (cmd.swap_rd)
        begin
            ra = idx_reg;
        end
        else if (req.kind == KIND_ADD)
        begin
            ra = filled_reg[AW-1:0];
        end
        else
        begin
            ra = req.position;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re_a)
        begin
            rd_a_reg <= mem[ra];
        end
        if (cmd.swap_rd)
        begin
            rd_b_reg <= mem[j_idx];
        end
    end

    // Generator, multiplier and remainder registers
    logic [63:0]   gen_reg, mul_a_reg, acc_reg;
    logic [63:0]   xs_v0, xs_v1, xs_v2, xs_v3;
    logic [31:0]   mul_x, mul_y;
    logic [63:0]   prod;
    logic [CW:0]   div_t, div_d;

    always_comb
    begin
        xs_v0 = (gen_reg == '0) ? GOLDEN : gen_reg;
        xs_v1 = xs_v0 ^ (xs_v0 >> XS_SHIFT_A);
        xs_v2 = xs_v1 ^ (xs_v1 << XS_SHIFT_B);
        xs_v3 = xs_v2 ^ (xs_v2 >> XS_SHIFT_C);
    end

    // Shared 32x32 multiplier, low 64 bits built in the mul0, mul1 and mul2 steps
    always_comb
    begin
        mul_x = mul_a_reg[31:0];
        mul_y = STAR_MUL[31:0];
        if (cmd.mul1)
        begin
            mul_x = mul_a_reg[63:32];
        end
        else if (cmd.mul2)
        begin
            mul_y = STAR_MUL[63:32];
        end
        prod = 64'(mul_x) * 64'(mul_y);
    end

    // Restoring remainder step, divisor i + 1
    assign div_t = {rem_reg, acc_reg[63]};
    assign div_d = {1'b0, CW'(idx_reg) + CW'(1)};

    always_ff @(posedge clk)
    begin
        if (cmd.accept && req.kind == KIND_SHUFFLE)
        begin
            gen_reg <= req.seed;
        end
        else if (cmd.xs)
        begin
            gen_reg <= xs_v3;
        end
        if (cmd.xs)
        begin
            mul_a_reg <= xs_v3;
        end
        if (cmd.mul0)
        begin
            acc_reg <= prod;
        end
        else if (cmd.mul1 || cmd.mul2)
        begin
            acc_reg <= acc_reg + {prod[31:0], 32'h0};
        end
        else if (cmd.div_step)
        begin
            acc_reg <= {acc_reg[62:0], 1'b0};
        end
        if (cmd.mul2)
        begin
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= (div_t >= div_d) ? CW'(div_t - div_d) : CW'(div_t);
        end
    end

    // Counters
    always_comb
    begin
        filled_next = filled_reg;
        if (kind_reg == KIND_CLEAR)
        begin
            filled_next = '0;
        end
        else if (add_ok)
        begin
            filled_next = filled_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg   <= '0;
            init_cnt_reg <= '0;
            idx_reg      <= '0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.finish)
            begin
                filled_reg <= filled_next;
            end
            if (cmd.init_step)
            begin
                init_cnt_reg <= init_cnt_reg + AW'(1);
            end
            if (cmd.accept)
            begin
                idx_reg <= AW'(filled_reg - CW'(1));
            end
            else if (cmd.wr_j)
            begin
                idx_reg <= idx_reg - AW'(1);
            end
            if (cmd.mul2)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 6'd1;
            end
        end
    end

    // Output word register
    logic          rsp_valid_reg;
    logic [1:0]    status_reg;
    logic [AW-1:0] slot_reg;
    logic [LW-1:0] rlen_reg;
    logic [CW-1:0] rfilled_reg;
    logic          full_reg, has_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg  <= ST_OK;
            slot_reg    <= '0;
            rlen_reg    <= '0;
            rfilled_reg <= filled_next;
            full_reg    <= filled_next >= eff_cap;
            has_reg     <= filled_next != '0;
            unique case (kind_reg)
                KIND_ADD:
                begin
                    if (bad_len)
                    begin
                        status_reg <= ST_BAD_LEN;
                    end
                    else if (is_full_now)
                    begin
                        status_reg <= ST_FULL;
                    end
                    else
                    begin
                        slot_reg <= rd_a_reg[EW-1:LW];
                        rlen_reg <= len_reg;
                    end
                end
                KIND_READ:
                begin
                    if (read_ok)
                    begin
                        slot_reg <= rd_a_reg[EW-1:LW];
                        rlen_reg <= rd_a_reg[LW-1:0];
                    end
                    else
                    begin
                        status_reg <= ST_NOT_FILLED;
                    end
                end
                default:
                begin
                    status_reg <= ST_OK;
                end
            endcase
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.buffer_slot = slot_reg;
    assign rsp.length      = rlen_reg;
    assign rsp.filled      = rfilled_reg;
    assign rsp.is_full     = full_reg;
    assign rsp.has_data    = has_reg;

    // Status to controller
    assign st.init_last = init_cnt_reg == AW'(BATCH_MAX - 1);
    assign st.shuf_run  = filled_reg >= CW'(2);
    assign st.div_last  = div_cnt_reg == 6'(DRAW_BITS - 1);
    assign st.idx_one   = idx_reg == AW'(1);
    assign st.out_free  = !rsp_valid_reg || rsp.ready;
    assign st.in_kind   = req.kind;

    // Checks
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!rsp_valid_reg || rsp.ready))
        else $error("result overwritten");
    a_swap_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.swap_rd |-> (j_idx <= idx_reg))
        else $error("draw out of range");
    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= CW'(BATCH_MAX))
        else $error("filled count overflow");

endmodule
